FILE: rtl/frame_subframe_slot_counter_assert.svh
// Assertion macros for the frame/subframe/slot counter.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef FRAME_SUBFRAME_SLOT_COUNTER_ASSERT_SVH
`define FRAME_SUBFRAME_SLOT_COUNTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FSS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/fss_pkg.sv
// Shared types and constants of the frame/subframe/slot counter.
// Used by every module of the block; depends on nothing.
package fss_pkg;

  localparam int unsigned SubframesPerFrame = 10;
  localparam logic [2:0]  MaxNumerology     = 3'd5;

  localparam int unsigned KeyRntiShift     = 48;
  localparam int unsigned KeyFrameShift    = 32;
  localparam int unsigned KeySubframeShift = 24;
  localparam int unsigned KeySlotShift     = 8;
  localparam int unsigned KeyNumShift      = 5;

  // Reciprocal of ten: floor(x * Recip10 / 2^35) equals x / 10 for any 32-bit x.
  localparam logic [31:0] Recip10      = 32'hCCCC_CCCD;
  localparam int unsigned Recip10Shift = 35;

  localparam logic FuncAdvance = 1'b0;
  localparam logic FuncLoad    = 1'b1;

  // Register index taken from paddr bit 2.
  localparam logic RegNumerology = 1'b0;

  typedef struct packed {
    logic        func;
    logic [31:0] slot_count;
    logic [31:0] new_frame;
    logic [3:0]  new_subframe;
    logic [4:0]  new_slot;
    logic [4:0]  sym_start;
    logic [15:0] rnti;
  } in_word_t;

  typedef struct packed {
    logic [31:0] frame_out;
    logic [3:0]  subframe_out;
    logic [4:0]  slot_out;
    logic [40:0] absolute_slot;
    logic [63:0] packed_key;
    logic        bad_position;
  } out_word_t;

  // An item after the slot count has been split into whole subframes (quot*10+rem)
  // and the slot count bits below one subframe (low).
  typedef struct packed {
    logic        func;
    logic [31:0] new_frame;
    logic [3:0]  new_subframe;
    logic [4:0]  new_slot;
    logic [4:0]  sym_start;
    logic [15:0] rnti;
    logic [4:0]  low;
    logic [28:0] quot;
    logic [3:0]  rem;
  } adv_t;

  // Position after one item, plus what the key needs.
  typedef struct packed {
    logic [31:0] frame;
    logic [3:0]  subframe;
    logic [4:0]  slot;
    logic [2:0]  num;
    logic [4:0]  sym_start;
    logic [15:0] rnti;
    logic        bad;
  } pos_t;

  // Per-stage load strobes, one for each registered stage below the input register.
  typedef struct packed {
    logic div_a;
    logic div_b;
    logic upd;
    logic fmt;
  } stage_take_t;

  // Slots per subframe minus one, for a numerology of at most five.
  function automatic logic [4:0] slot_mask(input logic [2:0] n);
    logic [5:0] spf;
    spf = 6'd1 << n;
    return 5'(spf - 6'd1);
  endfunction

endpackage

FILE: rtl/frame_subframe_slot_counter.sv
// Radio timing position counter: frame, subframe 0..9 and slot below 2^numerology.
// Depends on fss_pkg, fss_div10, fss_state, fss_fmt and the assertion macro header.
//
// Each input word either loads a position (rejected and flagged when the subframe
// is above nine or the slot does not fit the current numerology) or advances the
// position by a slot count, carrying into subframe and a frame number that wraps
// at 2^32. Every word yields exactly one result word with the new position, the
// absolute slot index and the packed 64-bit key. The block takes one word per
// clock unless a stalled output has filled every stage. Stages, in order, are:
// input register, slot count shift and multiply by the reciprocal of ten, remainder
// by ten, position update, and result formatting into the output register. Only the
// position update stage carries state from one word to the next; it holds a narrow
// add and a 32-bit three-input add, so consecutive words never wait for each other.
// Each stage moves on whenever the stage after it is empty or moving, so bubbles
// close up and in_stall_o rises only when all five stages hold words and the output
// is stalled. The numerology register (byte address 0) is written through the APB
// port; values six and seven act as five. Write it only while no word is in flight.

`include "frame_subframe_slot_counter_assert.svh"

module frame_subframe_slot_counter (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Input word channel.
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fss_pkg::in_word_t  in_word_i,
  // Result word channel.
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fss_pkg::out_word_t out_word_o,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [2:0]           num_q;
  logic [2:0]           n_eff;
  logic [4:0]           v_q;
  logic [4:0]           en;
  logic                 take_in;
  fss_pkg::stage_take_t take;
  fss_pkg::in_word_t    in_q;
  fss_pkg::adv_t        adv;
  fss_pkg::pos_t        pos;
  logic                 key_ok;

  // Configuration register. The numerology is saturated once here and the
  // saturated value drives all slot arithmetic and the key.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == fss_pkg::RegNumerology) ? {29'd0, num_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= '0;
    end else if (psel && penable && pwrite && paddr[2] == fss_pkg::RegNumerology) begin
      num_q <= pwdata[2:0];
    end
  end

  assign n_eff = (num_q > fss_pkg::MaxNumerology) ? fss_pkg::MaxNumerology : num_q;

  // Stage k may load when it is empty or when stage k+1 loads in the same cycle.
  // Stage 4 is the output register.
  always_comb begin
    en[4] = !v_q[4] || !out_stall_i;
    en[3] = !v_q[3] || en[4];
    en[2] = !v_q[2] || en[3];
    en[1] = !v_q[1] || en[2];
    en[0] = !v_q[0] || en[1];
    take_in    = in_valid_i && en[0];
    take.div_a = v_q[0] && en[1];
    take.div_b = v_q[1] && en[2];
    take.upd   = v_q[2] && en[3];
    take.fmt   = v_q[3] && en[4];
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
      if (en[3]) v_q[3] <= v_q[2];
      if (en[4]) v_q[4] <= v_q[3];
    end
  end

  // Input register.
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_q <= in_word_i;
    end
  end

  fss_div10 u_div10 (
    .clk_i  (clk_i),
    .n_i    (n_eff),
    .take_i (take),
    .word_i (in_q),
    .adv_o  (adv)
  );

  fss_state u_state (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .n_i    (n_eff),
    .take_i (take),
    .adv_i  (adv),
    .pos_o  (pos)
  );

  fss_fmt u_fmt (
    .clk_i  (clk_i),
    .take_i (take),
    .pos_i  (pos),
    .word_o (out_word_o)
  );

  // Low 16 frame bits, subframe and slot as they appear inside the key.
  assign key_ok = out_word_o.packed_key[47:32] == out_word_o.frame_out[15:0] &&
                  out_word_o.packed_key[27:24] == out_word_o.subframe_out &&
                  out_word_o.packed_key[12:8] == out_word_o.slot_out;

  // The input stalls only when every stage is occupied.
  `FSS_ASSERT_IMP(a_stall_only_full, in_stall_o, v_q == 5'b11111, "input stalled, stage free")

  // A delivered subframe is always a legal subframe number.
  `FSS_ASSERT_IMP(a_subframe_range, out_valid_o, out_word_o.subframe_out < 4'd10, "bad subframe")

  // The key carries the same low frame bits, subframe and slot as the result fields.
  `FSS_ASSERT_IMP(a_key_matches, out_valid_o, key_ok, "key disagrees with position")

  // A stalled output that stays stalled is still there in the next cycle.
  `FSS_ASSERT_NEXT(a_out_held, out_valid_o && out_stall_i, out_valid_o, "stalled result dropped")

endmodule

FILE: rtl/fss_div10.sv
// Two-stage split of the slot count into whole subframes divided by ten.
// Depends on fss_pkg.
module fss_div10 (
  input  logic             clk_i,
  input  logic [2:0]       n_i,
  input  fss_pkg::stage_take_t take_i,
  input  fss_pkg::in_word_t  word_i,
  output fss_pkg::adv_t      adv_o
);

  logic [31:0]   sub_cnt;
  logic [63:0]   prod;
  logic [31:0]   a_q;
  fss_pkg::adv_t st_a_d, st_a_q, st_b_d, st_b_q;
  logic [31:0]   q10;
  logic [31:0]   rem_full;

  // Whole subframes in the slot count, then its quotient by ten.
  always_comb begin
    sub_cnt = word_i.slot_count >> n_i;
    prod    = sub_cnt * fss_pkg::Recip10;
    st_a_d              = '0;
    st_a_d.func         = word_i.func;
    st_a_d.new_frame    = word_i.new_frame;
    st_a_d.new_subframe = word_i.new_subframe;
    st_a_d.new_slot     = word_i.new_slot;
    st_a_d.sym_start    = word_i.sym_start;
    st_a_d.rnti         = word_i.rnti;
    st_a_d.low          = word_i.slot_count[4:0] & fss_pkg::slot_mask(n_i);
    st_a_d.quot         = prod[63:fss_pkg::Recip10Shift];
  end

  // Remainder by ten from the quotient.
  always_comb begin
    q10      = {st_a_q.quot, 3'b000} + {2'b00, st_a_q.quot, 1'b0};
    rem_full = a_q - q10;
    st_b_d     = st_a_q;
    st_b_d.rem = rem_full[3:0];
  end

  always_ff @(posedge clk_i) begin
    if (take_i.div_a) begin
      st_a_q <= st_a_d;
      a_q    <= sub_cnt;
    end
    if (take_i.div_b) begin
      st_b_q <= st_b_d;
    end
  end

  assign adv_o = st_b_q;

endmodule

FILE: rtl/fss_state.sv
// Position registers and their update by load or advance.
// Depends on fss_pkg.
module fss_state (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [2:0]       n_i,
  input  fss_pkg::stage_take_t take_i,
  input  fss_pkg::adv_t      adv_i,
  output fss_pkg::pos_t      pos_o
);

  logic [31:0]   frame_q, frame_d;
  logic [3:0]    sub_q, sub_d;
  logic [4:0]    slot_q, slot_d;
  logic          bad;
  logic [5:0]    low_sum;
  logic [5:0]    carry;
  logic [6:0]    t_sum;
  logic [14:0]   t_prod;
  logic [3:0]    t_quot;
  logic [6:0]    t_rem;
  fss_pkg::pos_t pos_d, pos_q;

  always_comb begin
    // Slot bits below one subframe plus the stored slot; a stored slot above the
    // current subframe size carries out here as well.
    low_sum = {1'b0, adv_i.low} + {1'b0, slot_q};
    carry   = low_sum >> n_i;
    t_sum   = 7'(adv_i.rem) + 7'(sub_q) + 7'(carry);
    // t_sum stays below 87, where t*205/2048 is exact division by ten.
    t_prod  = 15'(t_sum) * 15'd205;
    t_quot  = t_prod[14:11];
    t_rem   = t_sum - 7'(t_quot) * 7'(fss_pkg::SubframesPerFrame);

    bad     = 1'b0;
    frame_d = frame_q;
    sub_d   = sub_q;
    slot_d  = slot_q;
    if (adv_i.func == fss_pkg::FuncLoad) begin
      if (adv_i.new_subframe > 4'(fss_pkg::SubframesPerFrame - 1) ||
          (adv_i.new_slot >> n_i) != 5'd0) begin
        bad = 1'b1;
      end else begin
        frame_d = adv_i.new_frame;
        sub_d   = adv_i.new_subframe;
        slot_d  = adv_i.new_slot;
      end
    end else begin
      frame_d = frame_q + 32'(adv_i.quot) + 32'(t_quot);
      sub_d   = t_rem[3:0];
      slot_d  = low_sum[4:0] & fss_pkg::slot_mask(n_i);
    end

    pos_d.frame     = frame_d;
    pos_d.subframe  = sub_d;
    pos_d.slot      = slot_d;
    pos_d.num       = n_i;
    pos_d.sym_start = adv_i.sym_start;
    pos_d.rnti      = adv_i.rnti;
    pos_d.bad       = bad;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
      sub_q   <= '0;
      slot_q  <= '0;
    end else if (take_i.upd) begin
      frame_q <= frame_d;
      sub_q   <= sub_d;
      slot_q  <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i.upd) begin
      pos_q <= pos_d;
    end
  end

  assign pos_o = pos_q;

endmodule

FILE: rtl/fss_fmt.sv
// Result formatting: absolute slot index and packed key into the output register.
// Depends on fss_pkg.
module fss_fmt (
  input  logic              clk_i,
  input  fss_pkg::stage_take_t take_i,
  input  fss_pkg::pos_t       pos_i,
  output fss_pkg::out_word_t  word_o
);

  logic [35:0]        frame10;
  logic [35:0]        base;
  fss_pkg::out_word_t word_d, word_q;

  always_comb begin
    frame10 = 36'({pos_i.frame, 3'b000}) + 36'({pos_i.frame, 1'b0});
    base    = frame10 + 36'(pos_i.subframe);

    word_d.frame_out     = pos_i.frame;
    word_d.subframe_out  = pos_i.subframe;
    word_d.slot_out      = pos_i.slot;
    word_d.absolute_slot = (41'(base) << pos_i.num) + 41'(pos_i.slot);
    word_d.packed_key    = (64'(pos_i.rnti)      << fss_pkg::KeyRntiShift)
                         | (64'(pos_i.frame)     << fss_pkg::KeyFrameShift)
                         | (64'(pos_i.subframe)  << fss_pkg::KeySubframeShift)
                         | (64'(pos_i.slot)      << fss_pkg::KeySlotShift)
                         | (64'(pos_i.num)       << fss_pkg::KeyNumShift)
                         | 64'(pos_i.sym_start);
    word_d.bad_position  = pos_i.bad;
  end

  always_ff @(posedge clk_i) begin
    if (take_i.fmt) begin
      word_q <= word_d;
    end
  end

  assign word_o = word_q;

endmodule
